[sv/lcdseq_pkg.sv]
// ----------------------------------------------------------------------------
// lcdseq_pkg: shared types and constants for the 4-bit LCD bus sequencer
// Word layouts for the request and pin channels, request codes, register
// indexes and the fixed command bytes of the init sequence.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

  localparam int unsigned CFG_W       = 20;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned NUM_CFG     = 6;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_E_PULSE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NIBBLE_GAP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_WAIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POWERUP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_WAIT1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_WAIT2 = 3'd5;

  // register reset values
  localparam logic [CFG_W-1:0] RST_E_PULSE    = 20'd2;
  localparam logic [CFG_W-1:0] RST_NIBBLE_GAP = 20'd40;
  localparam logic [CFG_W-1:0] RST_CLEAR_WAIT = 20'd2000;
  localparam logic [CFG_W-1:0] RST_POWERUP    = 20'd50000;
  localparam logic [CFG_W-1:0] RST_INIT_WAIT1 = 20'd5000;
  localparam logic [CFG_W-1:0] RST_INIT_WAIT2 = 20'd150;

  // request codes
  localparam logic [2:0] REQ_TICK     = 3'd0;
  localparam logic [2:0] REQ_WR_CMD   = 3'd1;
  localparam logic [2:0] REQ_WR_DATA  = 3'd2;
  localparam logic [2:0] REQ_RD_DATA  = 3'd3;
  localparam logic [2:0] REQ_WR_CHAR  = 3'd4;
  localparam logic [2:0] REQ_INIT     = 3'd5;

  // command and character bytes
  localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
  localparam logic [7:0] CMD_DISP_ON    = 8'h0C;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_HOME       = 8'h02;
  localparam logic [7:0] CMD_LINE2      = 8'hC0;
  localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [7:0] CHAR_RETURN    = 8'h0D;
  localparam logic [3:0] NIB_INIT_8BIT  = 4'h3;
  localparam logic [3:0] NIB_INIT_4BIT  = 4'h2;
  localparam logic [3:0] NIB_MASK       = 4'hF;

  // init steps: 1..3 send nibble 3, 4 sends nibble 2, 5..8 send command bytes
  localparam logic [3:0] STEP_NONE       = 4'd0;
  localparam logic [3:0] STEP_FIRST      = 4'd1;
  localparam logic [3:0] STEP_SECOND     = 4'd2;
  localparam logic [3:0] STEP_LAST_NIB   = 4'd4;
  localparam logic [3:0] STEP_FIRST_BYTE = 4'd5;
  localparam logic [3:0] STEP_CLEAR      = 4'd8;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] byte_value;
    logic [3:0] bus_nibble_in;
  } in_word_t;

  typedef struct packed {
    logic       pin_rs;
    logic       pin_rw;
    logic       pin_enable;
    logic [3:0] nibble_out;
    logic       drive_enable;
    logic       busy_res;
    logic       rejected;
    logic       read_valid;
    logic [7:0] read_byte;
  } out_word_t;

  function automatic logic [7:0] init_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = CMD_FUNC_SET;
      2'd1:    b = CMD_DISP_ON;
      2'd2:    b = CMD_ENTRY_MODE;
      default: b = CMD_CLEAR;
    endcase
    return b;
  endfunction

endpackage

[sv/char_lcd_4bit_bus_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// char_lcd_4bit_bus_sequencer_unit: character LCD sequencer for a 4-bit bus
// Steps the pin levels of the display bus by one tick per input word:
// init, command, data, read and character requests, two nibbles per byte.
// ----------------------------------------------------------------------------
//  channel  | ports                             | direction
//  ---------+-----------------------------------+----------
//  request  | in_valid, in_ready, in_data       | in
//  pins     | out_valid, out_ready, out_data    | out
//  config   | cfg_wr_en, cfg_index, cfg_wdata   | in
//
//  One word per cycle when ready: each accepted request or tick updates the
//  sequencer state in one pass and lands in the output register on the next
//  edge. in_ready drops only while the output register holds a word not yet
//  taken. Reset loads register defaults, clears the sequence and goes idle.
// ----------------------------------------------------------------------------
module char_lcd_4bit_bus_sequencer_unit #(
  parameter int unsigned TIMER_WIDTH = 20
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  lcdseq_pkg::in_word_t                       in_data,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output lcdseq_pkg::out_word_t                      out_data,
  input  logic                                       cfg_wr_en,
  input  logic [lcdseq_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [lcdseq_pkg::CFG_W-1:0]               cfg_wdata
);

  import lcdseq_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_POWERUP = 5'b00010,
    PH_EHIGH   = 5'b00100,
    PH_EGAP    = 5'b01000,
    PH_WAIT    = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    LA_NONE,
    LA_BYTE,
    LA_READ,
    LA_NIB
  } launch_t;

  typedef logic [TIMER_WIDTH-1:0] timer_t;

  // Clamp a register value to the timer range, zero optionally raised to one.
  function automatic timer_t sat_count(input logic [CFG_W-1:0] v, input logic at_least_one);
    logic [CFG_W-1:0] x;
    x = (at_least_one && (v == '0)) ? CFG_W'(1) : v;
    if ((x >> TIMER_WIDTH) != '0) return '1;
    return TIMER_WIDTH'(x);
  endfunction

  logic [CFG_W-1:0] cfg_r [NUM_CFG];

  phase_t     phase_r, phase_nxt;
  timer_t     timer_r, timer_nxt;
  logic [3:0] step_r, step_nxt;
  logic [7:0] pend_r, pend_nxt;
  logic       low_next_r, low_next_nxt;
  logic [7:0] racc_r, racc_nxt;
  logic       long_r, long_nxt;
  logic       rs_r, rs_nxt;
  logic       rw_r, rw_nxt;
  logic       en_r, en_nxt;
  logic [3:0] dat_r, dat_nxt;
  logic       drv_r, drv_nxt;

  logic      out_valid_r;
  out_word_t out_data_r, out_data_nxt;

  logic      accept;
  logic      is_req;
  logic      rejected;
  logic      rd_valid;
  logic [7:0] rd_byte;

  launch_t    la_kind;
  logic [7:0] la_byte;
  logic       la_rs;
  logic       la_long;
  logic [3:0] la_nib;

  logic [CFG_W-1:0] wait_val;
  logic [3:0]       step_inc;
  logic [3:0]       byte_off;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign is_req    = (in_data.req_type >= REQ_WR_CMD) && (in_data.req_type <= REQ_INIT);
  assign step_inc  = step_r + 4'd1;
  assign byte_off  = step_inc - STEP_FIRST_BYTE;

  always_comb begin
    phase_nxt    = phase_r;
    timer_nxt    = timer_r;
    step_nxt     = step_r;
    pend_nxt     = pend_r;
    low_next_nxt = low_next_r;
    racc_nxt     = racc_r;
    long_nxt     = long_r;
    rs_nxt       = rs_r;
    rw_nxt       = rw_r;
    en_nxt       = en_r;
    dat_nxt      = dat_r;
    drv_nxt      = drv_r;
    rejected     = 1'b0;
    rd_valid     = 1'b0;
    rd_byte      = '0;
    la_kind      = LA_NONE;
    la_byte      = '0;
    la_rs        = 1'b0;
    la_long      = 1'b0;
    la_nib       = '0;
    wait_val     = '0;

    if (phase_r != PH_IDLE) begin
      rejected = is_req;
      if (timer_r > TIMER_WIDTH'(1)) begin
        timer_nxt = timer_r - TIMER_WIDTH'(1);
      end else begin
        timer_nxt = '0;
        unique case (phase_r)
          PH_POWERUP: begin
            step_nxt = STEP_FIRST;
            la_kind  = LA_NIB;
            la_nib   = NIB_INIT_8BIT;
          end
          PH_EHIGH: begin
            // sample the bus as E falls
            if (rw_r) begin
              if (low_next_r) begin
                racc_nxt = {in_data.bus_nibble_in, 4'h0};
              end else begin
                racc_nxt = {racc_r[7:4], in_data.bus_nibble_in};
                rd_valid = 1'b1;
                rd_byte  = racc_nxt;
              end
            end
            phase_nxt = PH_EGAP;
            en_nxt    = 1'b0;
            timer_nxt = sat_count(cfg_r[REG_NIBBLE_GAP], 1'b1);
          end
          PH_EGAP: begin
            if (low_next_r) begin
              low_next_nxt = 1'b0;
              phase_nxt    = PH_EHIGH;
              en_nxt       = 1'b1;
              dat_nxt      = drv_r ? (pend_r[3:0] & NIB_MASK) : 4'h0;
              timer_nxt    = sat_count(cfg_r[REG_E_PULSE], 1'b1);
            end else begin
              if (step_r == STEP_FIRST)       wait_val = cfg_r[REG_INIT_WAIT1];
              else if (step_r == STEP_SECOND) wait_val = cfg_r[REG_INIT_WAIT2];
              else if (long_r)                wait_val = cfg_r[REG_CLEAR_WAIT];
              long_nxt = 1'b0;
              if (wait_val != '0) begin
                phase_nxt = PH_WAIT;
                en_nxt    = 1'b0;
                timer_nxt = sat_count(wait_val, 1'b0);
              end
            end
          end
          PH_WAIT: ;
          default: ;
        endcase

        // next unit: on wait expiry, or when a unit ends with no wait
        if ((phase_r == PH_WAIT) ||
            ((phase_r == PH_EGAP) && !low_next_r && (wait_val == '0))) begin
          if ((step_r >= STEP_FIRST) && (step_r < STEP_CLEAR)) begin
            step_nxt = step_inc;
            if (step_inc <= STEP_LAST_NIB) begin
              la_kind = LA_NIB;
              la_nib  = (step_inc == STEP_LAST_NIB) ? NIB_INIT_4BIT : NIB_INIT_8BIT;
            end else begin
              la_kind = LA_BYTE;
              la_byte = init_byte(byte_off[1:0]);
              la_rs   = 1'b0;
              la_long = (step_inc == STEP_CLEAR);
            end
          end else begin
            phase_nxt = PH_IDLE;
            timer_nxt = '0;
            step_nxt  = STEP_NONE;
            long_nxt  = 1'b0;
            en_nxt    = 1'b0;
          end
        end
      end
    end else if (is_req) begin
      step_nxt = STEP_NONE;
      case (in_data.req_type)
        REQ_WR_CMD: begin
          la_kind = LA_BYTE;
          la_byte = in_data.byte_value;
          la_rs   = 1'b0;
          la_long = (in_data.byte_value == CMD_CLEAR) || (in_data.byte_value == CMD_HOME);
        end
        REQ_WR_DATA: begin
          la_kind = LA_BYTE;
          la_byte = in_data.byte_value;
          la_rs   = 1'b1;
        end
        REQ_RD_DATA: begin
          la_kind = LA_READ;
        end
        REQ_WR_CHAR: begin
          la_kind = LA_BYTE;
          if (in_data.byte_value == CHAR_NEWLINE) begin
            la_byte = CMD_LINE2;
          end else if (in_data.byte_value == CHAR_RETURN) begin
            la_byte = CMD_HOME;
          end else begin
            la_byte = in_data.byte_value;
            la_rs   = 1'b1;
          end
        end
        default: begin
          rs_nxt   = 1'b0;
          rw_nxt   = 1'b0;
          en_nxt   = 1'b0;
          long_nxt = 1'b0;
          if (cfg_r[REG_POWERUP] == '0) begin
            step_nxt = STEP_FIRST;
            la_kind  = LA_NIB;
            la_nib   = NIB_INIT_8BIT;
          end else begin
            phase_nxt = PH_POWERUP;
            timer_nxt = sat_count(cfg_r[REG_POWERUP], 1'b0);
          end
        end
      endcase
    end

    // start a unit: raise E, with the first nibble on the bus for writes
    if (la_kind != LA_NONE) begin
      phase_nxt    = PH_EHIGH;
      en_nxt       = 1'b1;
      timer_nxt    = sat_count(cfg_r[REG_E_PULSE], 1'b1);
      case (la_kind)
        LA_BYTE: begin
          pend_nxt     = la_byte;
          rs_nxt       = la_rs;
          rw_nxt       = 1'b0;
          drv_nxt      = 1'b1;
          low_next_nxt = 1'b1;
          long_nxt     = la_long;
          dat_nxt      = la_byte[7:4];
        end
        LA_READ: begin
          rs_nxt       = 1'b1;
          rw_nxt       = 1'b1;
          drv_nxt      = 1'b0;
          low_next_nxt = 1'b1;
          long_nxt     = 1'b0;
          dat_nxt      = 4'h0;
        end
        default: begin
          rs_nxt       = 1'b0;
          rw_nxt       = 1'b0;
          drv_nxt      = 1'b1;
          low_next_nxt = 1'b0;
          long_nxt     = 1'b0;
          dat_nxt      = la_nib;
        end
      endcase
    end

    out_data_nxt.pin_rs       = rs_nxt;
    out_data_nxt.pin_rw       = rw_nxt;
    out_data_nxt.pin_enable   = en_nxt;
    out_data_nxt.nibble_out   = dat_nxt;
    out_data_nxt.drive_enable = drv_nxt;
    out_data_nxt.busy_res     = (phase_nxt != PH_IDLE);
    out_data_nxt.rejected     = rejected;
    out_data_nxt.read_valid   = rd_valid;
    out_data_nxt.read_byte    = rd_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[REG_E_PULSE]    <= RST_E_PULSE;
      cfg_r[REG_NIBBLE_GAP] <= RST_NIBBLE_GAP;
      cfg_r[REG_CLEAR_WAIT] <= RST_CLEAR_WAIT;
      cfg_r[REG_POWERUP]    <= RST_POWERUP;
      cfg_r[REG_INIT_WAIT1] <= RST_INIT_WAIT1;
      cfg_r[REG_INIT_WAIT2] <= RST_INIT_WAIT2;
    end else if (cfg_wr_en && (cfg_index < CFG_IDX_W'(NUM_CFG))) begin
      cfg_r[cfg_index] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      timer_r     <= '0;
      step_r      <= STEP_NONE;
      pend_r      <= '0;
      low_next_r  <= 1'b0;
      racc_r      <= '0;
      long_r      <= 1'b0;
      rs_r        <= 1'b0;
      rw_r        <= 1'b0;
      en_r        <= 1'b0;
      dat_r       <= '0;
      drv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r    <= phase_nxt;
        timer_r    <= timer_nxt;
        step_r     <= step_nxt;
        pend_r     <= pend_nxt;
        low_next_r <= low_next_nxt;
        racc_r     <= racc_nxt;
        long_r     <= long_nxt;
        rs_r       <= rs_nxt;
        rw_r       <= rw_nxt;
        en_r       <= en_nxt;
        dat_r      <= dat_nxt;
        drv_r      <= drv_nxt;
      end
      // hold the pin word until taken
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for char_lcd_4bit_bus_sequencer_unit
// Drives tick and request words through the valid/ready request channel and
// predicts the pin levels after every word with a cycle-free model of the
// sequencer. Each pin word is checked field by field in arrival order.
// Directed cases cover reset timings, zero waits, zero pulse and gap,
// character translation, rejection while busy, long waits, the register
// extremes and back-pressure with one long receiver hold-off. A random
// phase follows, with random timings, sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
  import lcdseq_pkg::*;

  localparam logic [2:0]       REQ_SPARE6  = 3'd6;
  localparam logic [2:0]       REQ_SPARE7  = 3'd7;
  localparam logic [CFG_W-1:0] CFG_MAX     = '1;
  localparam int unsigned      CYCLE_LIMIT = 200_000;
  localparam int unsigned      RANDOM_REQS = 20;
  localparam int unsigned      HOLD_CYCLES = 300;

  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_POWERUP, SEQ_E_HIGH, SEQ_E_LOW, SEQ_WAIT
  } seq_phase_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_word_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_word_t            out_data;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  char_lcd_4bit_bus_sequencer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // sequencer model state
  logic [CFG_W-1:0] cfg_shadow [NUM_CFG];
  seq_phase_t       seq_phase;
  logic [CFG_W-1:0] tmr;
  logic [3:0]       step;
  logic [7:0]       byte_q;
  logic [7:0]       rd_acc;
  logic             low_half_due;
  logic             clr_pending;
  logic             lvl_rs;
  logic             lvl_rw;
  logic             lvl_e;
  logic             lvl_drive;
  logic [3:0]       lvl_data;

  out_word_t pin_levels_q [$];
  out_word_t pin_exp;
  int        fail_count;
  int        cycle_count;
  int        burst_left;
  int        tx_gap_max;
  int        rx_mode;
  int        rx_left;
  bit        long_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ------------------------------------------------------------------ model
  function automatic logic [CFG_W-1:0] at_least_one(input logic [CFG_W-1:0] v);
    return (v == '0) ? {{(CFG_W-1){1'b0}}, 1'b1} : v;
  endfunction

  function automatic void model_reset();
    cfg_shadow[REG_E_PULSE]    = RST_E_PULSE;
    cfg_shadow[REG_NIBBLE_GAP] = RST_NIBBLE_GAP;
    cfg_shadow[REG_CLEAR_WAIT] = RST_CLEAR_WAIT;
    cfg_shadow[REG_POWERUP]    = RST_POWERUP;
    cfg_shadow[REG_INIT_WAIT1] = RST_INIT_WAIT1;
    cfg_shadow[REG_INIT_WAIT2] = RST_INIT_WAIT2;
    seq_phase    = SEQ_IDLE;
    tmr          = '0;
    step         = STEP_NONE;
    byte_q       = '0;
    rd_acc       = '0;
    low_half_due = 1'b0;
    clr_pending  = 1'b0;
    lvl_rs       = 1'b0;
    lvl_rw       = 1'b0;
    lvl_e        = 1'b0;
    lvl_drive    = 1'b0;
    lvl_data     = '0;
  endfunction

  function automatic void raise_e(input logic [3:0] nib);
    seq_phase = SEQ_E_HIGH;
    lvl_e     = 1'b1;
    lvl_data  = lvl_drive ? nib : 4'h0;
    tmr       = at_least_one(cfg_shadow[REG_E_PULSE]);
  endfunction

  function automatic void lower_e();
    seq_phase = SEQ_E_LOW;
    lvl_e     = 1'b0;
    tmr       = at_least_one(cfg_shadow[REG_NIBBLE_GAP]);
  endfunction

  function automatic void begin_byte(input logic [7:0] b, input logic rs, input logic lw);
    byte_q       = b;
    lvl_rs       = rs;
    lvl_rw       = 1'b0;
    lvl_drive    = 1'b1;
    low_half_due = 1'b1;
    clr_pending  = lw;
    raise_e(b[7:4]);
  endfunction

  function automatic void begin_read();
    lvl_rs       = 1'b1;
    lvl_rw       = 1'b1;
    lvl_drive    = 1'b0;
    low_half_due = 1'b1;
    clr_pending  = 1'b0;
    raise_e(4'h0);
  endfunction

  function automatic void send_init_unit(input logic [3:0] s);
    logic [7:0] cmd;
    if (s <= STEP_LAST_NIB) begin
      lvl_rs       = 1'b0;
      lvl_rw       = 1'b0;
      lvl_drive    = 1'b1;
      low_half_due = 1'b0;
      clr_pending  = 1'b0;
      raise_e(s == STEP_LAST_NIB ? NIB_INIT_4BIT : NIB_INIT_8BIT);
    end else begin
      case (s)
        STEP_FIRST_BYTE:         cmd = CMD_FUNC_SET;
        STEP_FIRST_BYTE + 4'd1:  cmd = CMD_DISP_ON;
        STEP_FIRST_BYTE + 4'd2:  cmd = CMD_ENTRY_MODE;
        default:                 cmd = CMD_CLEAR;
      endcase
      begin_byte(cmd, 1'b0, s == STEP_CLEAR);
    end
  endfunction

  function automatic void next_unit();
    if (step >= STEP_FIRST && step < STEP_CLEAR) begin
      step = step + 4'd1;
      send_init_unit(step);
    end else begin
      seq_phase   = SEQ_IDLE;
      tmr         = '0;
      step        = STEP_NONE;
      clr_pending = 1'b0;
      lvl_e       = 1'b0;
    end
  endfunction

  function automatic void unit_done();
    logic [CFG_W-1:0] w;
    w = '0;
    if (step == STEP_FIRST) w = cfg_shadow[REG_INIT_WAIT1];
    else if (step == STEP_SECOND) w = cfg_shadow[REG_INIT_WAIT2];
    else if (clr_pending) w = cfg_shadow[REG_CLEAR_WAIT];
    clr_pending = 1'b0;
    if (w != '0) begin
      seq_phase = SEQ_WAIT;
      lvl_e     = 1'b0;
      tmr       = w;
    end else begin
      next_unit();
    end
  endfunction

  function automatic void advance(input logic [3:0] nib, output logic valid,
                                  output logic [7:0] rbyte);
    valid = 1'b0;
    rbyte = '0;
    if (tmr > 1) begin
      tmr = tmr - 1'b1;
      return;
    end
    tmr = '0;
    case (seq_phase)
      SEQ_POWERUP: begin
        step = STEP_FIRST;
        send_init_unit(STEP_FIRST);
      end
      SEQ_E_HIGH: begin
        // sample the bus on the word where E falls
        if (lvl_rw) begin
          if (low_half_due) begin
            rd_acc = {nib, 4'h0};
          end else begin
            rd_acc[3:0] = nib;
            valid = 1'b1;
            rbyte = rd_acc;
          end
        end
        lower_e();
      end
      SEQ_E_LOW: begin
        if (low_half_due) begin
          low_half_due = 1'b0;
          raise_e(byte_q[3:0]);
        end else begin
          unit_done();
        end
      end
      SEQ_WAIT: next_unit();
      default: begin
        step = STEP_NONE;
        next_unit();
      end
    endcase
  endfunction

  // pin levels after one request or tick word
  function automatic out_word_t pins_after(input in_word_t w);
    out_word_t  r;
    logic       rej;
    logic       val;
    logic [7:0] rb;
    logic       is_req;
    rej    = 1'b0;
    val    = 1'b0;
    rb     = '0;
    is_req = (w.req_type >= REQ_WR_CMD) && (w.req_type <= REQ_INIT);
    if (seq_phase != SEQ_IDLE) begin
      rej = is_req;
      advance(w.bus_nibble_in, val, rb);
    end else if (is_req) begin
      step = STEP_NONE;
      case (w.req_type)
        REQ_WR_CMD:
          begin_byte(w.byte_value, 1'b0,
                     w.byte_value == CMD_CLEAR || w.byte_value == CMD_HOME);
        REQ_WR_DATA: begin_byte(w.byte_value, 1'b1, 1'b0);
        REQ_RD_DATA: begin_read();
        REQ_WR_CHAR: begin
          if (w.byte_value == CHAR_NEWLINE) begin_byte(CMD_LINE2, 1'b0, 1'b0);
          else if (w.byte_value == CHAR_RETURN) begin_byte(CMD_HOME, 1'b0, 1'b0);
          else begin_byte(w.byte_value, 1'b1, 1'b0);
        end
        default: begin
          lvl_rs      = 1'b0;
          lvl_rw      = 1'b0;
          lvl_e       = 1'b0;
          clr_pending = 1'b0;
          if (cfg_shadow[REG_POWERUP] == '0) begin
            step = STEP_FIRST;
            send_init_unit(STEP_FIRST);
          end else begin
            seq_phase = SEQ_POWERUP;
            tmr       = cfg_shadow[REG_POWERUP];
          end
        end
      endcase
    end
    r.pin_rs       = lvl_rs;
    r.pin_rw       = lvl_rw;
    r.pin_enable   = lvl_e;
    r.nibble_out   = lvl_data;
    r.drive_enable = lvl_drive;
    r.busy_res     = (seq_phase != SEQ_IDLE);
    r.rejected     = rej;
    r.read_valid   = val;
    r.read_byte    = rb;
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic send_word(input in_word_t w);
    int gap;
    gap = 0;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      if (tx_gap_max > 0) gap = $urandom_range(0, tx_gap_max);
    end
    burst_left--;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    pin_levels_q.push_back(pins_after(w));
  endtask

  function automatic in_word_t tick_word();
    in_word_t w;
    w.req_type      = ($urandom_range(0, 9) == 0) ?
                      ($urandom_range(0, 1) ? REQ_SPARE7 : REQ_SPARE6) : REQ_TICK;
    w.byte_value    = 8'($urandom);
    w.bus_nibble_in = 4'($urandom);
    return w;
  endfunction

  task automatic run_to_idle(input int reject_pct);
    in_word_t w;
    while (seq_phase != SEQ_IDLE) begin
      w = tick_word();
      if ($urandom_range(1, 100) <= reject_pct)
        w.req_type = 3'($urandom_range(REQ_WR_CMD, REQ_INIT));
      send_word(w);
    end
  endtask

  task automatic issue(input logic [2:0] req, input logic [7:0] b);
    in_word_t w;
    w.req_type      = req;
    w.byte_value    = b;
    w.bus_nibble_in = 4'($urandom);
    send_word(w);
    run_to_idle(3);
  endtask

  // drop valid and let every pin word come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pin_levels_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_wr_en  <= 1'b1;
    cfg_index  <= idx;
    cfg_wdata  <= val;
    cfg_shadow[idx] = val;
    @(negedge clk);
    cfg_wr_en  <= 1'b0;
  endtask

  task automatic set_timing(input logic [CFG_W-1:0] pulse, input logic [CFG_W-1:0] gap,
                            input logic [CFG_W-1:0] clr, input logic [CFG_W-1:0] pwr,
                            input logic [CFG_W-1:0] w1, input logic [CFG_W-1:0] w2);
    drain();
    cfg_write(REG_E_PULSE, pulse);
    cfg_write(REG_NIBBLE_GAP, gap);
    cfg_write(REG_CLEAR_WAIT, clr);
    cfg_write(REG_POWERUP, pwr);
    cfg_write(REG_INIT_WAIT1, w1);
    cfg_write(REG_INIT_WAIT2, w2);
  endtask

  // ------------------------------------------------------------------ tests
  task automatic test_reset_timing();
    // default pulse and gap; skip the long default waits
    issue(REQ_WR_CHAR, 8'h48);
  endtask

  task automatic test_zero_waits();
    set_timing(20'd1, 20'd1, 20'd0, 20'd0, 20'd0, 20'd0);
    issue(REQ_WR_CMD, 8'hFF);
    issue(REQ_WR_CMD, 8'h00);
    issue(REQ_WR_DATA, 8'hA5);
    issue(REQ_RD_DATA, 8'h00);
    issue(REQ_WR_CHAR, CHAR_NEWLINE);
    issue(REQ_WR_CHAR, CHAR_RETURN);
    issue(REQ_WR_CHAR, 8'h7E);
    issue(REQ_INIT, 8'hFF);
    issue(REQ_SPARE6, 8'h00);
  endtask

  task automatic test_zero_pulse_gap();
    set_timing(20'd0, 20'd0, 20'd3, 20'd2, 20'd1, 20'd1);
    issue(REQ_WR_CMD, CMD_CLEAR);
    issue(REQ_RD_DATA, 8'h00);
  endtask

  task automatic test_busy_reject();
    in_word_t w;
    set_timing(20'd2, 20'd3, 20'd5, 20'd4, 20'd2, 20'd2);
    w = '{req_type: REQ_WR_DATA, byte_value: 8'h3C, bus_nibble_in: 4'h0};
    send_word(w);
    w = '{req_type: REQ_WR_CMD, byte_value: 8'h80, bus_nibble_in: 4'hF};
    send_word(w);
    w = '{req_type: REQ_INIT, byte_value: 8'h00, bus_nibble_in: 4'h5};
    send_word(w);
    w = '{req_type: REQ_RD_DATA, byte_value: 8'hFF, bus_nibble_in: 4'hA};
    send_word(w);
    run_to_idle(0);
  endtask

  task automatic test_long_waits();
    set_timing(20'd2, 20'd2, 20'd6, 20'd10, 20'd5, 20'd3);
    issue(REQ_INIT, 8'h00);
    issue(REQ_WR_CMD, CMD_HOME);
  endtask

  task automatic test_register_extremes();
    // hold the waits at full scale and use only requests that skip them
    set_timing(20'd1, 20'd2, CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX);
    issue(REQ_WR_DATA, 8'h00);
    issue(REQ_WR_CHAR, CHAR_RETURN);
    issue(REQ_WR_CMD, 8'h80);
    issue(REQ_RD_DATA, 8'h00);
    set_timing(CFG_MAX, CFG_MAX, 20'd0, 20'd0, 20'd0, 20'd0);
    repeat (20) send_word(tick_word());
  endtask

  task automatic test_backpressure();
    in_word_t w;
    set_timing(20'd1, 20'd1, 20'd2, 20'd0, 20'd0, 20'd0);
    tx_gap_max = 0;
    long_hold  = 1'b1;
    repeat (60) begin
      w = tick_word();
      if ($urandom_range(0, 2) == 0) w.req_type = 3'($urandom_range(REQ_WR_CMD, REQ_INIT));
      send_word(w);
    end
    run_to_idle(0);
  endtask

  task automatic test_random();
    logic [2:0] req;
    logic [7:0] b;
    int         sel;
    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i % 5 == 0) begin
        set_timing(CFG_W'($urandom_range(0, 2)), CFG_W'($urandom_range(0, 2)),
                   ($urandom_range(0, 3) == 0) ? '0 : CFG_W'($urandom_range(1, 8)),
                   ($urandom_range(0, 3) == 0) ? '0 : CFG_W'($urandom_range(1, 10)),
                   CFG_W'($urandom_range(0, 6)), CFG_W'($urandom_range(0, 4)));
        tx_gap_max = ((i / 5) % 3) * 4;
      end
      sel = $urandom_range(0, 99);
      if (sel < 20) req = REQ_WR_CMD;
      else if (sel < 40) req = REQ_WR_DATA;
      else if (sel < 60) req = REQ_RD_DATA;
      else if (sel < 82) req = REQ_WR_CHAR;
      else if (sel < 90) req = REQ_INIT;
      else req = tick_word().req_type;
      b = 8'($urandom);
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 3))
          0:       b = CMD_CLEAR;
          1:       b = CMD_HOME;
          2:       b = CHAR_NEWLINE;
          default: b = CHAR_RETURN;
        endcase
      end
      issue(req, b);
    end
  endtask

  // --------------------------------------------------------------- receiver
  initial begin
    out_ready = 1'b0;
    rx_mode   = 0;
    rx_left   = 0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
      end else begin
        if (rx_left <= 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        case (rx_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= ($urandom_range(0, 2) == 0);
          default: out_ready <= (rx_left % 4 != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- checker
  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pin_levels_q.size() == 0) begin
        $error("pin word with no word pending");
        fail_count++;
      end else begin
        pin_exp = pin_levels_q.pop_front();
        check_field("pin_rs", pin_exp.pin_rs, out_data.pin_rs);
        check_field("pin_rw", pin_exp.pin_rw, out_data.pin_rw);
        check_field("pin_enable", pin_exp.pin_enable, out_data.pin_enable);
        check_field("nibble_out", pin_exp.nibble_out, out_data.nibble_out);
        check_field("drive_enable", pin_exp.drive_enable, out_data.drive_enable);
        check_field("busy_res", pin_exp.busy_res, out_data.busy_res);
        check_field("rejected", pin_exp.rejected, out_data.rejected);
        check_field("read_valid", pin_exp.read_valid, out_data.read_valid);
        check_field("read_byte", pin_exp.read_byte, out_data.read_byte);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("char_lcd_4bit_bus_sequencer_unit test failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------- main
  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_wr_en  = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    fail_count = 0;
    burst_left = 0;
    tx_gap_max = 3;
    long_hold  = 1'b0;
    model_reset();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_timing();
    test_zero_waits();
    test_zero_pulse_gap();
    test_busy_reject();
    test_long_waits();
    test_register_extremes();
    test_backpressure();
    test_random();

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("char_lcd_4bit_bus_sequencer_unit test passed");
    else
      $display("char_lcd_4bit_bus_sequencer_unit test failed");
    $finish;
  end

endmodule

[char_lcd_4bit_bus_sequencer_unit.f]
sv/lcdseq_pkg.sv
sv/char_lcd_4bit_bus_sequencer_unit.sv
tb/sv/testbench.sv
